// ===== design/grc_pkg.sv =====
`default_nettype none
package grc_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int MAP_BITS    = 6;
   localparam int ADDR_W      = 2 * MAP_BITS;
   localparam int MPOS_W      = MAP_BITS + 2;
   localparam int SCREEN_COLS = 1280;
   localparam int SCREEN_ROWS = 720;
   localparam int COL_W       = 11;
   localparam int ROW_W       = 10;
   localparam int POS_W       = 22;
   localparam int DIR_W       = 18;
   localparam int CAM_W       = 19;
   localparam int PROD_W      = DIR_W + CAM_W;
   localparam int RAY_W       = PROD_W - FRAC_BITS;
   localparam int MAG_W       = RAY_W;
   localparam int DELTA_W     = 2 * FRAC_BITS + 1;
   localparam int DIST_W      = 42;
   localparam int DOUT_W      = 24;
   localparam int LH_W        = 11;
   localparam int SHADE_W     = 8;
   localparam int FRACSEL_W   = FRAC_BITS + 1;
   localparam int DIV_NW      = DELTA_W;
   localparam int DIV_DW      = 27;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = POS_W;

   // camera offset col * 2^17 / SCREEN_COLS = col * 2^9 / 5, by reciprocal 2^22 / 5
   localparam int CAM_RECIP_W = 20;
   localparam int CAM_PROD_W  = COL_W + CAM_RECIP_W;
   localparam int CAM_SHIFT   = 13;
   localparam logic [CAM_RECIP_W-1:0] CAM_RECIP = 20'd838861;

   // fog blend num / (20 * 2^16) = (num >> 18) / 5, by reciprocal 2^12 / 5
   localparam int SNUM_W       = 28;
   localparam int SHADE_HI_W   = 10;
   localparam int SHADE_PROD_W = 2 * SHADE_HI_W;
   localparam logic [SHADE_HI_W-1:0] SHADE_RECIP = 10'd820;

   localparam logic [POS_W-1:0] POS_RESET     = 22'd2129920;
   localparam logic [DIR_W-1:0] DIR_X_RESET   = 18'h30000;
   localparam logic [DIR_W-1:0] DIR_Y_RESET   = 18'h00000;
   localparam logic [DIR_W-1:0] PLANE_X_RESET = 18'h00000;
   localparam logic [DIR_W-1:0] PLANE_Y_RESET = 18'd43254;

   localparam logic [DIST_W-1:0] FOG_DIST  = DIST_W'(20 * (1 << FRAC_BITS));
   localparam logic [LH_W-1:0]   LH_MAX    = LH_W'(2 * SCREEN_ROWS);
   localparam logic [ROW_W-1:0]  ROW_HALF  = ROW_W'(SCREEN_ROWS / 2);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [ROW_W-1:0]  ROW_COUNT = ROW_W'(SCREEN_ROWS);
   localparam logic [SHADE_W-1:0] FOG_SHADE = 8'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POS_X   = 3'd0,
      CSR_POS_Y   = 3'd1,
      CSR_DIR_X   = 3'd2,
      CSR_DIR_Y   = 3'd3,
      CSR_PLANE_X = 3'd4,
      CSR_PLANE_Y = 3'd5
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CAM,
      ST_RAY_MUL,
      ST_RAY_SUM,
      ST_X_DIV,
      ST_X_SIDE,
      ST_Y_DIV,
      ST_Y_SIDE,
      ST_STEP,
      ST_CHECK,
      ST_LH_DIV,
      ST_SHADE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      DIV_DX,
      DIV_DY,
      DIV_LH
   } div_sel_type;

   typedef struct packed {
      logic        req_ready;
      logic        tile_we;
      logic        clear_en;
      logic        col_load;
      logic        div_start;
      div_sel_type div_sel;
      logic        cam_load;
      logic        ray_mul;
      logic        ray_sum;
      logic        dx_load;
      logic        side_x_load;
      logic        dy_load;
      logic        side_y_load;
      logic        step;
      logic        lh_load;
      logic        shade_load;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic hit;
      logic clear_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== design/grc_req_if.sv =====
`default_nettype none
interface grc_req_if import grc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [MAP_BITS-1:0]  tile_x;
   logic [MAP_BITS-1:0]  tile_y;
   logic                 tile_is_wall;
   logic [COL_W-1:0]     screen_col;

   modport source (output valid, req_type, tile_x, tile_y, tile_is_wall, screen_col,
                   input ready);
   modport sink (input valid, req_type, tile_x, tile_y, tile_is_wall, screen_col,
                 output ready);
endinterface
`default_nettype wire

// ===== design/grc_rsp_if.sv =====
`default_nettype none
interface grc_rsp_if import grc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COL_W-1:0]    col_out;
   logic [DOUT_W-1:0]   wall_distance;
   logic                hit_side;
   logic [ROW_W-1:0]    draw_start;
   logic [ROW_W-1:0]    draw_end;
   logic [SHADE_W-1:0]  shade;

   modport source (output valid, col_out, wall_distance, hit_side, draw_start, draw_end,
                   shade, input ready);
   modport sink (input valid, col_out, wall_distance, hit_side, draw_start, draw_end,
                 shade, output ready);
endinterface
`default_nettype wire

// ===== design/grc_divider.sv =====
`default_nettype none
module grc_divider import grc_pkg::*; #(
   parameter int NW = DIV_NW,
   parameter int DW = DIV_DW
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               busy,
   output logic               done,
   output logic [NW-1:0]      quotient
);

   localparam int CNT_W = $clog2(NW + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [DW-1:0]     rem_ff;
   logic [DW-1:0]     dvs_ff;
   logic [NW-1:0]     quo_ff;
   logic [DW:0]       trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[NW-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(NW);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvs_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? DW'(trial - {1'b0, dvs_ff}) : trial[DW-1:0];
         quo_ff <= {quo_ff[NW-2:0], fits};
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== design/grc_datapath.sv =====
`default_nettype none
module grc_datapath import grc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [MAP_BITS-1:0]   tile_x,
   input  wire logic [MAP_BITS-1:0]   tile_y,
   input  wire logic                  tile_is_wall,
   input  wire logic [COL_W-1:0]      screen_col,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [COL_W-1:0]           col_out,
   output logic [DOUT_W-1:0]          wall_distance,
   output logic                       hit_side,
   output logic [ROW_W-1:0]           draw_start,
   output logic [ROW_W-1:0]           draw_end,
   output logic [SHADE_W-1:0]         shade
);

   logic [POS_W-1:0]          pos_x_ff, pos_y_ff;
   logic [DIR_W-1:0]          dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic [COL_W-1:0]          col_ff;
   logic signed [CAM_W-1:0]   cam_ff;
   logic signed [PROD_W-1:0]  prod_x_ff, prod_y_ff;
   logic [RAY_W-1:0]          ray_x_ff, ray_y_ff;
   logic [MAG_W-1:0]          mag_x, mag_y;
   logic [DELTA_W-1:0]        delta_x_ff, delta_y_ff;
   logic [DIST_W-1:0]         side_x_ff, side_y_ff, perp_ff;
   logic                      inf_x_ff, inf_y_ff, perp_inf_ff, side_ff;
   logic [MPOS_W-1:0]         mx_ff, my_ff, mx_in, my_in;
   logic                      step_x;
   logic [FRACSEL_W-1:0]      frac_x, frac_y;
   logic [FRACSEL_W+DELTA_W-1:0] sprod_x, sprod_y;
   logic [LH_W-1:0]           lh_ff;
   logic                      rsp_valid_ff;
   logic [ADDR_W-1:0]         clr_ff;
   logic                      mem [0:(1<<ADDR_W)-1];
   logic                      rd_ff;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic                      mem_wdata;

   logic [DIV_NW-1:0]         div_dividend, div_quo;
   logic [DIV_DW-1:0]         div_divisor, perp_div;
   logic                      div_busy, div_done;
   logic [CAM_PROD_W-1:0]     cam_prod;
   logic [SNUM_W-1:0]         shade_num, shade_num_ff;
   logic [SNUM_W-1:0]         shade_base, shade_sub;
   logic [SHADE_PROD_W-1:0]   shade_prod;
   logic [SHADE_W-1:0]        shade_ff;
   logic [ROW_W-1:0]          half;
   logic [LH_W-1:0]           end_sum;
   logic                      perp_big;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= POS_RESET;
         pos_y_ff   <= POS_RESET;
         dir_x_ff   <= DIR_X_RESET;
         dir_y_ff   <= DIR_Y_RESET;
         plane_x_ff <= PLANE_X_RESET;
         plane_y_ff <= PLANE_Y_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POS_X:   pos_x_ff   <= csr_wdata[POS_W-1:0];
            CSR_POS_Y:   pos_y_ff   <= csr_wdata[POS_W-1:0];
            CSR_DIR_X:   dir_x_ff   <= csr_wdata[DIR_W-1:0];
            CSR_DIR_Y:   dir_y_ff   <= csr_wdata[DIR_W-1:0];
            CSR_PLANE_X: plane_x_ff <= csr_wdata[DIR_W-1:0];
            CSR_PLANE_Y: plane_y_ff <= csr_wdata[DIR_W-1:0];
            default: ;
         endcase
      end
   end

   // map store: clearing sweep after reset, tile writes, registered read
   assign mem_we    = cmd.clear_en | cmd.tile_we;
   assign mem_waddr = cmd.clear_en ? clr_ff : {tile_y, tile_x};
   assign mem_wdata = cmd.clear_en | tile_is_wall;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[{my_in[MAP_BITS-1:0], mx_in[MAP_BITS-1:0]}];
   end

   // shared divider
   assign perp_big = perp_inf_ff | (|perp_ff[DIST_W-1:DIV_DW]);
   assign perp_div = perp_big ? '1 : perp_ff[DIV_DW-1:0];
   assign shade_base = side_ff ? 28'd196608000 : 28'd131072000;
   assign shade_sub  = side_ff ? 28'(perp_ff[20:0] * 7'd100) : 28'(perp_ff[20:0] * 7'd50);
   assign shade_num  = shade_base - shade_sub;

   always_comb begin
      case (cmd.div_sel)
         DIV_DX: begin
            div_dividend = DIV_NW'(1) << (2 * FRAC_BITS);
            div_divisor  = DIV_DW'(mag_x);
         end
         DIV_DY: begin
            div_dividend = DIV_NW'(1) << (2 * FRAC_BITS);
            div_divisor  = DIV_DW'(mag_y);
         end
         DIV_LH: begin
            div_dividend = DIV_NW'(SCREEN_ROWS) << FRAC_BITS;
            div_divisor  = perp_div;
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   grc_divider #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ray setup
   assign cam_prod   = col_ff * CAM_RECIP;
   assign shade_prod = shade_num_ff[SNUM_W-1 -: SHADE_HI_W] * SHADE_RECIP;

   assign mag_x  = ray_x_ff[RAY_W-1] ? MAG_W'(-ray_x_ff) : ray_x_ff;
   assign mag_y  = ray_y_ff[RAY_W-1] ? MAG_W'(-ray_y_ff) : ray_y_ff;
   assign frac_x = ray_x_ff[RAY_W-1] ? {1'b0, pos_x_ff[FRAC_BITS-1:0]}
                                     : FRACSEL_W'((1 << FRAC_BITS)) - {1'b0, pos_x_ff[FRAC_BITS-1:0]};
   assign frac_y = ray_y_ff[RAY_W-1] ? {1'b0, pos_y_ff[FRAC_BITS-1:0]}
                                     : FRACSEL_W'((1 << FRAC_BITS)) - {1'b0, pos_y_ff[FRAC_BITS-1:0]};
   assign sprod_x = frac_x * delta_x_ff;
   assign sprod_y = frac_y * delta_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.col_load) begin
         col_ff <= screen_col;
      end
      if (cmd.cam_load) begin
         cam_ff <= $signed({1'b0, cam_prod[CAM_SHIFT+CAM_W-2:CAM_SHIFT]})
                   - CAM_W'(1 << FRAC_BITS);
      end
      if (cmd.ray_mul) begin
         prod_x_ff <= $signed(plane_x_ff) * cam_ff;
         prod_y_ff <= $signed(plane_y_ff) * cam_ff;
      end
      if (cmd.ray_sum) begin
         ray_x_ff <= {{(RAY_W-DIR_W){dir_x_ff[DIR_W-1]}}, dir_x_ff}
                     + prod_x_ff[PROD_W-1:FRAC_BITS];
         ray_y_ff <= {{(RAY_W-DIR_W){dir_y_ff[DIR_W-1]}}, dir_y_ff}
                     + prod_y_ff[PROD_W-1:FRAC_BITS];
      end
      if (cmd.dx_load) begin
         delta_x_ff <= div_quo;
      end
      if (cmd.dy_load) begin
         delta_y_ff <= div_quo;
      end
      if (cmd.lh_load) begin
         lh_ff        <= (div_quo > DIV_NW'(LH_MAX)) ? LH_MAX : div_quo[LH_W-1:0];
         shade_num_ff <= shade_num;
      end
      if (cmd.shade_load) begin
         shade_ff <= (perp_inf_ff || perp_ff >= FOG_DIST) ? FOG_SHADE
                                                          : shade_prod[SHADE_PROD_W-1 -: SHADE_W];
      end
   end

   // grid walk
   assign step_x = !inf_x_ff && (inf_y_ff || side_x_ff < side_y_ff);

   always_comb begin
      mx_in = mx_ff;
      my_in = my_ff;
      if (step_x) begin
         mx_in = ray_x_ff[RAY_W-1] ? mx_ff - 1'b1 : mx_ff + 1'b1;
      end else begin
         my_in = ray_y_ff[RAY_W-1] ? my_ff - 1'b1 : my_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.side_x_load) begin
         side_x_ff <= DIST_W'(sprod_x[FRACSEL_W+DELTA_W-1:FRAC_BITS]);
         inf_x_ff  <= ray_x_ff == '0;
      end
      if (cmd.side_y_load) begin
         side_y_ff <= DIST_W'(sprod_y[FRACSEL_W+DELTA_W-1:FRAC_BITS]);
         inf_y_ff  <= ray_y_ff == '0;
         mx_ff     <= MPOS_W'(pos_x_ff[POS_W-1:FRAC_BITS]);
         my_ff     <= MPOS_W'(pos_y_ff[POS_W-1:FRAC_BITS]);
      end
      if (cmd.step) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
         if (step_x) begin
            perp_ff     <= side_x_ff;
            perp_inf_ff <= 1'b0;
            side_x_ff   <= side_x_ff + DIST_W'(delta_x_ff);
            side_ff     <= 1'b0;
         end else begin
            perp_ff     <= side_y_ff;
            perp_inf_ff <= inf_y_ff;
            side_y_ff   <= side_y_ff + DIST_W'(delta_y_ff);
            side_ff     <= 1'b1;
         end
      end
   end

   // result
   assign half    = lh_ff[LH_W-1:1];
   assign end_sum = LH_W'(half) + LH_W'(ROW_HALF);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         col_out       <= col_ff;
         wall_distance <= (perp_inf_ff | (|perp_ff[DIST_W-1:DOUT_W])) ? '1
                                                                      : perp_ff[DOUT_W-1:0];
         hit_side      <= side_ff;
         draw_start    <= (half <= ROW_HALF) ? ROW_HALF - half : '0;
         draw_end      <= (end_sum >= LH_W'(ROW_COUNT)) ? ROW_LAST : end_sum[ROW_W-1:0];
         shade         <= shade_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign status.div_busy   = div_busy;
   assign status.div_done   = div_done;
   assign status.hit        = mx_ff[MPOS_W-1] | mx_ff[MAP_BITS] | my_ff[MPOS_W-1]
                              | my_ff[MAP_BITS] | rd_ff;
   assign status.clear_last = &clr_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

`ifndef ASSERT_OFF
   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending item");
   a_write_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.tile_we |-> !cmd.clear_en)
      else $error("tile write during map clear");
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider restarted while busy");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> $past(div_busy))
      else $error("divider done without a division");
`endif

endmodule
`default_nettype wire

// ===== design/grc_ctrl.sv =====
`default_nettype none
module grc_ctrl import grc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_is_cast,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      div_kick;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:     if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid && req_is_cast) state_in = ST_CAM;
         ST_CAM:       state_in = ST_RAY_MUL;
         ST_RAY_MUL:   state_in = ST_RAY_SUM;
         ST_RAY_SUM:   state_in = ST_X_DIV;
         ST_X_DIV:     if (status.div_done) state_in = ST_X_SIDE;
         ST_X_SIDE:    state_in = ST_Y_DIV;
         ST_Y_DIV:     if (status.div_done) state_in = ST_Y_SIDE;
         ST_Y_SIDE:    state_in = ST_STEP;
         ST_STEP:      state_in = ST_CHECK;
         ST_CHECK:     state_in = status.hit ? ST_LH_DIV : ST_STEP;
         ST_LH_DIV:    if (status.div_done) state_in = ST_SHADE;
         ST_SHADE:     state_in = ST_FINISH;
         ST_FINISH:    if (status.out_free) state_in = ST_IDLE;
         default:      state_in = ST_CLEAR;
      endcase
   end

   assign div_kick = !status.div_busy && !status.div_done;

   always_comb begin
      cmd = '0;
      cmd.div_sel = DIV_DX;
      case (state_ff)
         ST_CLEAR: cmd.clear_en = 1'b1;
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.tile_we   = req_valid && !req_is_cast;
            cmd.col_load  = req_valid && req_is_cast;
         end
         ST_CAM:     cmd.cam_load = 1'b1;
         ST_RAY_MUL: cmd.ray_mul = 1'b1;
         ST_RAY_SUM: cmd.ray_sum = 1'b1;
         ST_X_DIV: begin
            cmd.div_sel   = DIV_DX;
            cmd.div_start = div_kick;
            cmd.dx_load   = status.div_done;
         end
         ST_X_SIDE: cmd.side_x_load = 1'b1;
         ST_Y_DIV: begin
            cmd.div_sel   = DIV_DY;
            cmd.div_start = div_kick;
            cmd.dy_load   = status.div_done;
         end
         ST_Y_SIDE: cmd.side_y_load = 1'b1;
         ST_STEP:   cmd.step = 1'b1;
         ST_CHECK:  ;
         ST_LH_DIV: begin
            cmd.div_sel   = DIV_LH;
            cmd.div_start = div_kick;
            cmd.lh_load   = status.div_done;
         end
         ST_SHADE:  cmd.shade_load = 1'b1;
         ST_FINISH: cmd.out_load = status.out_free;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== design/grid_raycast_column.sv =====
// Wall-column raycaster over a 64 x 64 tile map.
// req_chan (valid/ready) takes items: a tile write (req_type 0) stores one
// wall bit and gives no result; a cast (req_type 1) walks the
// ray for screen_col through the map and gives one item on rsp_chan
// (valid/ready) with distance, side, draw rows and shade.
// csr_we/csr_index/csr_wdata write the camera registers: position x, y,
// direction x, y, camera plane x, y (indexes 0 to 5); write only while idle.
// A cast runs camera and ray setup, two reciprocal divisions on the shared
// bit-serial divider, a walk of n grid steps (1 to about 128), each a step
// and a check state, a slice-height division and the shade and finish
// states; the next item can be taken in the cycle the result appears.
// One item is in work at a time; req_chan.ready is low during a cast.
// After reset the map is swept to all walls, one tile a cycle over all 4096
// tiles, with req_chan.ready low; registers return to their reset camera.
// The result waits in an output register while rsp_chan.ready is low; the
// next item is still taken, and a later cast holds at its end until the
// register is free.
`default_nettype none
module grid_raycast_column import grc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   grc_req_if.sink                    req_chan,
   grc_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   grc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_is_cast (req_chan.req_type),
      .status      (status),
      .cmd         (cmd)
   );

   grc_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .tile_x        (req_chan.tile_x),
      .tile_y        (req_chan.tile_y),
      .tile_is_wall  (req_chan.tile_is_wall),
      .screen_col    (req_chan.screen_col),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .col_out       (rsp_chan.col_out),
      .wall_distance (rsp_chan.wall_distance),
      .hit_side      (rsp_chan.hit_side),
      .draw_start    (rsp_chan.draw_start),
      .draw_end      (rsp_chan.draw_end),
      .shade         (rsp_chan.shade)
   );

   assign req_chan.ready = cmd.req_ready;

endmodule
`default_nettype wire

// ===== verif/tb_grid_raycast_column.sv =====
`default_nettype none
module tb_grid_raycast_column import grc_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                req_type;
      logic [MAP_BITS-1:0] tile_x;
      logic [MAP_BITS-1:0] tile_y;
      logic                tile_is_wall;
      logic [COL_W-1:0]    screen_col;
   } ray_req_type;

   typedef struct {
      logic [COL_W-1:0]   col;
      logic [DOUT_W-1:0]  distance;
      logic               side;
      logic [ROW_W-1:0]   row_first;
      logic [ROW_W-1:0]   row_end;
      logic [SHADE_W-1:0] gray;
   } column_type;

   localparam logic [63:0] CAP = 64'd1 << 62;
   localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

   class column_scoreboard_type;
      bit          tiles[4096];
      logic [63:0] vx, vy;
      longint      dxr, dyr, px, py;
      column_type  pending[$];
      int          errors;
      int          casts;

      function new();
         foreach (tiles[i]) tiles[i] = 1'b1;
         vx = 64'(POS_RESET);
         vy = 64'(POS_RESET);
         dxr = longint'(signed'(DIR_X_RESET));
         dyr = longint'(signed'(DIR_Y_RESET));
         px = longint'(signed'(PLANE_X_RESET));
         py = longint'(signed'(PLANE_Y_RESET));
      endfunction

      function void write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_POS_X:   vx = 64'(v);
            CSR_POS_Y:   vy = 64'(v);
            CSR_DIR_X:   dxr = longint'(signed'(v[DIR_W-1:0]));
            CSR_DIR_Y:   dyr = longint'(signed'(v[DIR_W-1:0]));
            CSR_PLANE_X: px = longint'(signed'(v[DIR_W-1:0]));
            CSR_PLANE_Y: py = longint'(signed'(v[DIR_W-1:0]));
            default: ;
         endcase
      endfunction

      function logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
         return a * (b >> FRAC_BITS) + ((a * (b & (ONE - 1))) >> FRAC_BITS);
      endfunction

      function void axis(input longint d, input logic [63:0] p, output int st,
                         output logic [63:0] dl, output logic [63:0] sd);
         logic [63:0] frac, mag;
         frac = p & (ONE - 1);
         if (d == 0) begin
            st = 1; dl = CAP; sd = CAP;
            return;
         end
         mag = (d < 0) ? 64'(-d) : 64'(d);
         dl = (64'd1 << (2 * FRAC_BITS)) / mag;
         if (d < 0) begin
            st = -1;
            sd = fx_mul(frac, dl);
         end else begin
            st = 1;
            sd = fx_mul(ONE - frac, dl);
         end
      endfunction

      function void note_input(ray_req_type r);
         longint cam, rx, ry, mx, my;
         int stx, sty;
         logic [63:0] dx, dy, sx, sy, perp, lh, half, rs, re, base, g;
         column_type c;
         bit side;
         if (!r.req_type) begin
            tiles[{r.tile_y, r.tile_x}] = r.tile_is_wall;
            return;
         end
         casts++;
         cam = longint'(((64'(r.screen_col) * 2) << FRAC_BITS) / SCREEN_COLS) - longint'(ONE);
         rx = dxr + ((px * cam) >>> FRAC_BITS);
         ry = dyr + ((py * cam) >>> FRAC_BITS);
         mx = longint'(vx >> FRAC_BITS);
         my = longint'(vy >> FRAC_BITS);
         axis(rx, vx, stx, dx, sx);
         axis(ry, vy, sty, dy, sy);
         perp = 0;
         side = 0;
         forever begin
            if (sx < sy) begin
               perp = sx; sx = (sx + dx > CAP) ? CAP : sx + dx; mx += stx; side = 0;
            end else begin
               perp = sy; sy = (sy + dy > CAP) ? CAP : sy + dy; my += sty; side = 1;
            end
            if (mx < 0 || mx > 63 || my < 0 || my > 63) break;
            if (tiles[my * 64 + mx]) break;
         end
         if (perp == 0) lh = 2 * SCREEN_ROWS;
         else begin
            lh = (64'(SCREEN_ROWS) << FRAC_BITS) / perp;
            if (lh > 2 * SCREEN_ROWS) lh = 2 * SCREEN_ROWS;
         end
         half = lh / 2;
         rs = (SCREEN_ROWS / 2 >= half) ? SCREEN_ROWS / 2 - half : 0;
         re = half + SCREEN_ROWS / 2;
         if (re >= SCREEN_ROWS) re = SCREEN_ROWS - 1;
         base = side ? 150 : 100;
         if (perp >= 20 * ONE) g = 50;
         else g = (base * 20 * ONE - (base - 50) * perp) / (20 * ONE);
         c.col = r.screen_col;
         c.distance = (perp > 64'hFFFFFF) ? 24'hFFFFFF : perp[DOUT_W-1:0];
         c.side = side;
         c.row_first = rs[ROW_W-1:0];
         c.row_end = re[ROW_W-1:0];
         c.gray = g[SHADE_W-1:0];
         pending = {pending, c};
      endfunction

      function void check(column_type a);
         column_type e;
         if (pending.size() == 0) begin
            $error("unexpected result for column %0d", a.col);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.col !== e.col) begin
            $error("col_out exp %0d got %0d", e.col, a.col); errors++;
         end
         if (a.distance !== e.distance) begin
            $error("wall_distance exp %0h got %0h", e.distance, a.distance); errors++;
         end
         if (a.side !== e.side) begin
            $error("hit_side exp %0d got %0d", e.side, a.side); errors++;
         end
         if (a.row_first !== e.row_first) begin
            $error("draw_start exp %0d got %0d", e.row_first, a.row_first); errors++;
         end
         if (a.row_end !== e.row_end) begin
            $error("draw_end exp %0d got %0d", e.row_end, a.row_end); errors++;
         end
         if (a.gray !== e.gray) begin
            $error("shade exp %0d got %0d", e.gray, a.gray); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int tiles_sent = 0;
   int cfg_writes = 0;
   longint cycles = 0;
   column_scoreboard_type sb = new();

   grc_req_if req_chan ();
   grc_rsp_if rsp_chan ();

   grid_raycast_column dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.req_type = 1'b0;
      req_chan.tile_x = '0;
      req_chan.tile_y = '0;
      req_chan.tile_is_wall = 1'b0;
      req_chan.screen_col = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      column_type got;
      cycles <= cycles + 1;
      if (cycles > 4000000) begin
         $display("grid_raycast_column regression: fail");
         $finish;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.col = rsp_chan.col_out;
         got.distance = rsp_chan.wall_distance;
         got.side = rsp_chan.hit_side;
         got.row_first = rsp_chan.draw_start;
         got.row_end = rsp_chan.draw_end;
         got.gray = rsp_chan.shade;
         sb.check(got);
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_gap_pct);
   end

   task automatic send(ray_req_type r);
      if ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= r.req_type;
      req_chan.tile_x <= r.tile_x;
      req_chan.tile_y <= r.tile_y;
      req_chan.tile_is_wall <= r.tile_is_wall;
      req_chan.screen_col <= r.screen_col;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_input(r);
      if (!r.req_type) tiles_sent++;
   endtask

   task automatic tile(int x, int y, bit w);
      ray_req_type r;
      r.req_type = 1'b0;
      r.tile_x = MAP_BITS'(x);
      r.tile_y = MAP_BITS'(y);
      r.tile_is_wall = w;
      r.screen_col = COL_W'($urandom);
      send(r);
   endtask

   task automatic cast(int c);
      ray_req_type r;
      r.req_type = 1'b1;
      r.tile_x = MAP_BITS'($urandom);
      r.tile_y = MAP_BITS'($urandom);
      r.tile_is_wall = 1'($urandom);
      r.screen_col = COL_W'(c);
      send(r);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, int v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(v);
      sb.write_reg(idx, CSR_DATA_W'(v));
      cfg_writes++;
      @(posedge clock);
   endtask

   task automatic camera(int x, int y, int dx, int dy, int qx, int qy);
      write_reg(CSR_POS_X, x);
      write_reg(CSR_POS_Y, y);
      write_reg(CSR_DIR_X, dx);
      write_reg(CSR_DIR_Y, dy);
      write_reg(CSR_PLANE_X, qx);
      write_reg(CSR_PLANE_Y, qy);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int rand_dir();
      case ($urandom_range(5))
         0: return -131072;
         1: return 131071;
         2: return 0;
         default: return $urandom_range(262143) - 131072;
      endcase
   endfunction

   initial begin
      int cx, cy;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default camera, walls everywhere, then open a room
      cast(0);
      cast(1279);
      tile(0, 0, 1'b1);
      tile(63, 63, 1'b0);
      for (int i = 26; i < 39; i++) tile(i, 32, 1'b0);
      tile(32, 33, 1'b0);
      cast(640);
      cast(1280);
      cast(2047);
      drain();
      camera(32 << 16, 32 << 16, -65536, 0, 0, 43254);
      cast(640);
      cast(0);
      drain();
      camera(0, 4194303, 0, 0, 0, 0);
      cast(640);
      cast(1279);
      drain();
      camera(4194303, 0, 131071, -131072, -131072, 131071);
      cast(0);
      cast(2047);

      for (int ph = 0; ph < 12; ph++) begin
         drain();
         send_gap_pct = (ph < 4) ? 13 : (ph < 8) ? 70 : 0;
         recv_gap_pct = (ph < 4) ? 70 : (ph < 8) ? 13 : 0;
         if (ph % 3 == 0)
            camera($urandom_range(4194303), $urandom_range(4194303),
                   rand_dir(), rand_dir(), rand_dir(), rand_dir());
         else
            camera($urandom_range(16 << 16, 48 << 16), $urandom_range(16 << 16, 48 << 16),
                   rand_dir(), rand_dir(), rand_dir(), rand_dir());
         cx = int'(sb.vx >> FRAC_BITS);
         cy = int'(sb.vy >> FRAC_BITS);
         for (int n = 0; n < 135; n++) begin
            case ($urandom_range(9))
               0, 1, 2, 3:
                  tile(cx + $urandom_range(20) - 10, cy + $urandom_range(20) - 10,
                       $urandom_range(9) < 2);
               4:
                  tile($urandom_range(63), $urandom_range(63), 1'($urandom));
               5:
                  cast($urandom_range(2047));
               default:
                  cast($urandom_range(1279));
            endcase
         end
      end

      drain();
      repeat (600) @(posedge clock);
      $display("covered %0d casts, %0d tile writes, %0d register writes",
               sb.casts, tiles_sent, cfg_writes);
      $display("under sender and receiver stalls, extreme cameras and open rooms");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("grid_raycast_column regression: pass");
      else
         $display("grid_raycast_column regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
design/grc_pkg.sv
design/grc_req_if.sv
design/grc_rsp_if.sv
design/grc_divider.sv
design/grc_datapath.sv
design/grc_ctrl.sv
design/grid_raycast_column.sv
verif/tb_grid_raycast_column.sv
